@@ rtl/ctc_pkg.sv @@
package ctc_pkg;

	// Sizes fixed by the item fields.
	localparam int POS_W      = 12;
	localparam int LEN_W      = 8;
	localparam int KIND_W     = 3;
	localparam int KW_IDX_W   = 5;
	localparam int OP_IDX_W   = 2;
	localparam int KW_TABLE   = 32;
	localparam int KW_MAX_LEN = 8;
	localparam int POS_CAP    = 4095;

	localparam int DEF_LINE_LENGTH   = 4096;
	localparam int DEF_KEYWORD_COUNT = 32;

	localparam logic [LEN_W-1:0] LEN_MAX = 8'd255;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_KEYWORD  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_REAL     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_IDENT    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_BAD_ID   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_OPERATOR = 3'd4;

	// Operator codes.
	localparam logic [OP_IDX_W-1:0] OP_PLUS  = 2'd0;
	localparam logic [OP_IDX_W-1:0] OP_MINUS = 2'd1;
	localparam logic [OP_IDX_W-1:0] OP_STAR  = 2'd2;
	localparam logic [OP_IDX_W-1:0] OP_SLASH = 2'd3;

	// Character codes.
	localparam logic [7:0] CH_SPACE  = " ";
	localparam logic [7:0] CH_PLUS   = "+";
	localparam logic [7:0] CH_MINUS  = "-";
	localparam logic [7:0] CH_STAR   = "*";
	localparam logic [7:0] CH_SLASH  = "/";
	localparam logic [7:0] CH_COMMA  = ",";
	localparam logic [7:0] CH_SEMI   = ";";
	localparam logic [7:0] CH_LPAREN = "(";
	localparam logic [7:0] CH_RPAREN = ")";
	localparam logic [7:0] CH_LBRACE = "{";
	localparam logic [7:0] CH_RBRACE = "}";
	localparam logic [7:0] CH_LBRACK = "[";
	localparam logic [7:0] CH_RBRACK = "]";
	localparam logic [7:0] CH_POINT  = ".";
	localparam logic [7:0] CH_ZERO   = "0";
	localparam logic [7:0] CH_NINE   = "9";

	// Keyword text, right aligned in 64 bits, with the length of each word.
	localparam logic [63:0] KW_STR [KW_TABLE] = '{
		64'("auto"), 64'("break"), 64'("case"), 64'("char"),
		64'("const"), 64'("continue"), 64'("default"), 64'("do"),
		64'("double"), 64'("else"), 64'("enum"), 64'("extern"),
		64'("float"), 64'("for"), 64'("goto"), 64'("if"),
		64'("int"), 64'("long"), 64'("register"), 64'("return"),
		64'("short"), 64'("signed"), 64'("sizeof"), 64'("static"),
		64'("struct"), 64'("switch"), 64'("typedef"), 64'("union"),
		64'("unsigned"), 64'("void"), 64'("volatile"), 64'("while")
	};

	localparam logic [3:0] KW_LEN [KW_TABLE] = '{
		4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd2,
		4'd6, 4'd4, 4'd4, 4'd6, 4'd5, 4'd3, 4'd4, 4'd2,
		4'd3, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6,
		4'd6, 4'd6, 4'd7, 4'd5, 4'd8, 4'd4, 4'd8, 4'd5
	};

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [KW_IDX_W-1:0] kw_idx;
		logic [OP_IDX_W-1:0] op_idx;
		logic [POS_W-1:0]    start;
		logic [LEN_W-1:0]    length;
	} result_t;

	// Results of one character: up to two, the first in res0.
	typedef struct packed {
		logic [1:0] count;
		result_t    res0;
		result_t    res1;
	} lex_out_t;

	// Byte n of keyword k, counted from its first letter; zero past its end.
	function automatic logic [7:0] kw_byte(input int k, input logic [2:0] n);
		logic [63:0] w;
		int          sh;
		w  = '0;
		sh = 0;
		if ({1'b0, n} < KW_LEN[k]) begin
			sh = 8 * (int'(KW_LEN[k]) - 1 - int'(n));
			w  = KW_STR[k] >> sh;
		end
		return w[7:0];
	endfunction

	function automatic logic is_delim(input logic [7:0] c);
		return c == CH_SPACE || c == CH_PLUS || c == CH_MINUS || c == CH_STAR ||
		       c == CH_SLASH || c == CH_COMMA || c == CH_SEMI || c == CH_LPAREN ||
		       c == CH_RPAREN || c == CH_LBRACE || c == CH_RBRACE ||
		       c == CH_LBRACK || c == CH_RBRACK;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic [KIND_W-1:0] token_kind(input logic found, input logic ddo,
	                                                 input logic point, input logic swd);
		logic [KIND_W-1:0] k;
		if (found) begin
			k = KIND_KEYWORD;
		end else if (ddo && point) begin
			k = KIND_REAL;
		end else if (!swd) begin
			k = KIND_IDENT;
		end else begin
			k = KIND_BAD_ID;
		end
		return k;
	endfunction

endpackage

@@ rtl/c_token_classifier.sv @@
// Channel | Direction | Handshake           | Payload
// in      | into      | in_valid, in_stall  | character, end_of_line
// out     | out of    | out_valid, out_stall| kind, keyword_index, operator_index,
//         |           |                     | token_start, token_length, last_of_run
//
// An item sits in the input register; its results go into the result register
// when it moves on, so a new character is taken every cycle while that register
// has room. A character that gives two results (a token ended by + - * or /)
// makes the next character wait in the input register while the second result
// drains from the two-entry result register; that register sets the rate.
// Reset clears the token state, the line position and all valid flags at once.
// in_stall rises only when the input register is full and cannot move on.
module c_token_classifier #(
	parameter int LINE_LENGTH   = ctc_pkg::DEF_LINE_LENGTH,
	parameter int KEYWORD_COUNT = ctc_pkg::DEF_KEYWORD_COUNT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [7:0]                   character,
	input  logic                         end_of_line,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [ctc_pkg::KIND_W-1:0]   kind,
	output logic [ctc_pkg::KW_IDX_W-1:0] keyword_index,
	output logic [ctc_pkg::OP_IDX_W-1:0] operator_index,
	output logic [ctc_pkg::POS_W-1:0]    token_start,
	output logic [ctc_pkg::LEN_W-1:0]    token_length,
	output logic                         last_of_run
);
	import ctc_pkg::*;

	// Input register.
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eol_s1;

	// Result register: up to two results of one character, the older in res0_q.
	logic [1:0] cnt_q;
	result_t    res0_q;
	result_t    res1_q;

	lex_out_t   lex;
	logic       in_take;
	logic       out_take;
	logic       buf_free;
	logic       step;

	assign out_take = out_valid && !out_stall;
	// The result register can take a new pair when it will be empty by this edge.
	assign buf_free = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_take);
	assign step     = valid_s1 && buf_free;
	assign in_stall = valid_s1 && !step;
	assign in_take  = in_valid && !in_stall;

	ctc_lexer #(
		.LINE_LENGTH   (LINE_LENGTH),
		.KEYWORD_COUNT (KEYWORD_COUNT)
	) u_lexer (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.character   (char_s1),
		.end_of_line (eol_s1),
		.lex         (lex)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			char_s1 <= character;
			eol_s1  <= end_of_line;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (step) begin
			cnt_q <= lex.count;
		end else if (out_take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Payload only moves when the front result has gone or is going.
	always_ff @(posedge clk) begin
		if (step) begin
			res0_q <= lex.res0;
			res1_q <= lex.res1;
		end else if (out_take && cnt_q == 2'd2) begin
			res0_q <= res1_q;
		end
	end

	assign out_valid      = cnt_q != 2'd0;
	assign kind           = res0_q.kind;
	assign keyword_index  = res0_q.kw_idx;
	assign operator_index = res0_q.op_idx;
	assign token_start    = res0_q.start;
	assign token_length   = res0_q.length;
	// The register only ever holds results of one character, so the last one is
	// the one shown when a single result is left.
	assign last_of_run    = cnt_q == 2'd1;

endmodule

@@ rtl/ctc_kw_match.sv @@
module ctc_kw_match #(
	parameter int KEYWORD_COUNT = ctc_pkg::DEF_KEYWORD_COUNT
) (
	input  logic [ctc_pkg::KW_TABLE-1:0] cand_q,
	input  logic [ctc_pkg::LEN_W-1:0]    plen_q,
	input  logic [7:0]                   character,
	input  logic                         use_next,
	input  logic [ctc_pkg::LEN_W-1:0]    len_next,
	output logic [ctc_pkg::KW_TABLE-1:0] cand_next,
	output logic                         found,
	output logic [ctc_pkg::KW_IDX_W-1:0] kw_idx
);
	import ctc_pkg::*;

	localparam int KW_USED = (KEYWORD_COUNT < KW_TABLE) ? KEYWORD_COUNT : KW_TABLE;

	logic [KW_TABLE-1:0] cand_sel;
	logic [KW_TABLE-1:0] hit;
	logic [LEN_W-1:0]    len_sel;
	logic                short_tok;

	// Each keyword stays a candidate while its next letter equals this character.
	always_comb begin
		short_tok = plen_q < LEN_W'(KW_MAX_LEN);
		for (int i = 0; i < KW_TABLE; i++) begin
			cand_next[i] = cand_q[i] && short_tok && ({4'd0, KW_LEN[i]} > plen_q) &&
			               (kw_byte(i, plen_q[2:0]) == character);
		end
	end

	// The lowest keyword that survives with exactly the token's length wins.
	always_comb begin
		cand_sel = use_next ? cand_next : cand_q;
		len_sel  = use_next ? len_next : plen_q;
		found    = 1'b0;
		kw_idx   = '0;
		for (int i = 0; i < KW_TABLE; i++) begin
			hit[i] = cand_sel[i] && (i < KW_USED) && ({4'd0, KW_LEN[i]} == len_sel);
		end
		for (int i = KW_TABLE - 1; i >= 0; i--) begin
			if (hit[i]) begin
				found  = 1'b1;
				kw_idx = KW_IDX_W'(i);
			end
		end
	end

endmodule

@@ rtl/ctc_lexer.sv @@
module ctc_lexer #(
	parameter int LINE_LENGTH   = ctc_pkg::DEF_LINE_LENGTH,
	parameter int KEYWORD_COUNT = ctc_pkg::DEF_KEYWORD_COUNT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        character,
	input  logic              end_of_line,
	output ctc_pkg::lex_out_t lex
);
	import ctc_pkg::*;

	localparam int POS_LIM = ((LINE_LENGTH - 1) < POS_CAP) ? (LINE_LENGTH - 1) : POS_CAP;
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(POS_LIM);

	logic [KW_TABLE-1:0] cand_q;
	logic [LEN_W-1:0]    plen_q;
	logic [POS_W-1:0]    pstart_q;
	logic [POS_W-1:0]    line_q;
	logic                swd_q;
	logic                ddo_q;
	logic                point_q;

	logic [KW_TABLE-1:0] cand_n;
	logic [LEN_W-1:0]    plen_n;
	logic [POS_W-1:0]    pstart_n;
	logic                swd_n;
	logic                ddo_n;
	logic                point_n;
	logic                delim;
	logic                digit;
	logic                dot;
	logic                kw_found;
	logic [KW_IDX_W-1:0] kw_idx;
	logic                tok_valid;
	logic                op_valid;
	logic [OP_IDX_W-1:0] op_idx;
	result_t             tok;
	result_t             opr;

	ctc_kw_match #(
		.KEYWORD_COUNT(KEYWORD_COUNT)
	) u_kw_match (
		.cand_q    (cand_q),
		.plen_q    (plen_q),
		.character (character),
		.use_next  (!delim),
		.len_next  (plen_n),
		.cand_next (cand_n),
		.found     (kw_found),
		.kw_idx    (kw_idx)
	);

	always_comb begin
		delim = is_delim(character);
		digit = is_digit(character);
		dot   = character == CH_POINT;

		case (character)
			CH_PLUS:  op_idx = OP_PLUS;
			CH_MINUS: op_idx = OP_MINUS;
			CH_STAR:  op_idx = OP_STAR;
			CH_SLASH: op_idx = OP_SLASH;
			default:  op_idx = OP_PLUS;
		endcase
		op_valid = delim && (character == CH_PLUS || character == CH_MINUS ||
		                     character == CH_STAR || character == CH_SLASH);

		pstart_n = (plen_q == '0) ? line_q : pstart_q;
		swd_n    = (plen_q == '0) ? digit : swd_q;
		ddo_n    = ddo_q && (digit || dot);
		point_n  = point_q || dot;
		plen_n   = (plen_q == LEN_MAX) ? plen_q : plen_q + LEN_W'(1);

		tok_valid = delim ? (plen_q != '0) : end_of_line;

		tok.kw_idx = kw_found ? kw_idx : '0;
		tok.op_idx = OP_PLUS;
		if (delim) begin
			tok.kind   = token_kind(kw_found, ddo_q, point_q, swd_q);
			tok.start  = pstart_q;
			tok.length = plen_q;
		end else begin
			tok.kind   = token_kind(kw_found, ddo_n, point_n, swd_n);
			tok.start  = pstart_n;
			tok.length = plen_n;
		end

		opr.kind   = KIND_OPERATOR;
		opr.kw_idx = '0;
		opr.op_idx = op_idx;
		opr.start  = line_q;
		opr.length = LEN_W'(1);

		lex.count = {1'b0, tok_valid} + {1'b0, op_valid};
		lex.res0  = tok_valid ? tok : opr;
		lex.res1  = opr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q   <= '1;
			plen_q   <= '0;
			pstart_q <= '0;
			line_q   <= '0;
			swd_q    <= 1'b0;
			ddo_q    <= 1'b1;
			point_q  <= 1'b0;
		end else if (step) begin
			if (delim || end_of_line) begin
				cand_q   <= '1;
				plen_q   <= '0;
				pstart_q <= '0;
				swd_q    <= 1'b0;
				ddo_q    <= 1'b1;
				point_q  <= 1'b0;
			end else begin
				cand_q   <= cand_n;
				plen_q   <= plen_n;
				pstart_q <= pstart_n;
				swd_q    <= swd_n;
				ddo_q    <= ddo_n;
				point_q  <= point_n;
			end
			if (end_of_line) begin
				line_q <= '0;
			end else if (line_q < POS_MAX) begin
				line_q <= line_q + POS_W'(1);
			end
		end
	end

endmodule

@@ tb/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ctc_pkg::*;

	// One result of the lexer, laid out as it appears on the output ports.
	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [KW_IDX_W-1:0] kw_idx;
		logic [OP_IDX_W-1:0] op_idx;
		logic [POS_W-1:0]    start;
		logic [LEN_W-1:0]    length;
		logic                last;
	} token_report_t;

	// A row of the opening sequence. Where typed is set, want is the result the
	// character must give, written out by hand; otherwise the lexer model decides.
	typedef struct {
		logic [7:0]    ch;
		logic          eol;
		logic          typed;
		token_report_t want;
	} stim_row_t;

	localparam int            PERIOD       = 12;
	localparam int            LIMIT_CYCLES = 2_000_000;
	localparam token_report_t NO_REPORT    = '0;
	localparam int            POS_LIMIT    = (DEF_LINE_LENGTH - 1 < POS_CAP) ?
	                                         DEF_LINE_LENGTH - 1 : POS_CAP;
	localparam int            KW_IN_USE    = (DEF_KEYWORD_COUNT < KW_TABLE) ?
	                                         DEF_KEYWORD_COUNT : KW_TABLE;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [7:0]            character = 8'h00;
	logic                  end_of_line = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [KIND_W-1:0]     kind;
	logic [KW_IDX_W-1:0]   keyword_index;
	logic [OP_IDX_W-1:0]   operator_index;
	logic [POS_W-1:0]      token_start;
	logic [LEN_W-1:0]      token_length;
	logic                  last_of_run;

	c_token_classifier uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.character      (character),
		.end_of_line    (end_of_line),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.keyword_index  (keyword_index),
		.operator_index (operator_index),
		.token_start    (token_start),
		.token_length   (token_length),
		.last_of_run    (last_of_run)
	);

	always #(PERIOD / 2) clk = ~clk;

	// The keyword list in its fixed order; the index of a word here is the
	// keyword_index the block must give for it.
	string c_keywords [KW_TABLE] = '{
		"auto", "break", "case", "char", "const", "continue", "default", "do",
		"double", "else", "enum", "extern", "float", "for", "goto", "if",
		"int", "long", "register", "return", "short", "signed", "sizeof", "static",
		"struct", "switch", "typedef", "union", "unsigned", "void", "volatile", "while"
	};

	// Every character that ends a token; + - * and / are also operators.
	string stops = " +-*/,;(){}[]";

	// Results still owed by the block, oldest first.
	token_report_t expected_reports [$];
	// Characters of the line being sent.
	logic [7:0]    line_buf [$];

	int gap_pct = 0;
	int stall_pct = 0;
	int chars_sent = 0;
	int failures = 0;

	// Lexer state: the token being gathered and the position within the line.
	logic [KW_TABLE-1:0] kw_live;
	logic [LEN_W-1:0]    tok_len;
	logic [POS_W-1:0]    tok_start;
	logic [POS_W-1:0]    line_pos;
	logic                first_digit;
	logic                numeric_only;
	logic                has_point;

	function automatic logic is_numeral(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic splits_token(input logic [7:0] c);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < stops.len(); i++) begin
			if (stops[i] == c) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	// Returns whether c is an operator and, if so, which one.
	function automatic logic operator_of(input logic [7:0] c, output logic [OP_IDX_W-1:0] op);
		logic is_op;
		is_op = 1'b1;
		op = OP_PLUS;
		case (c)
			CH_PLUS:  op = OP_PLUS;
			CH_MINUS: op = OP_MINUS;
			CH_STAR:  op = OP_STAR;
			CH_SLASH: op = OP_SLASH;
			default:  is_op = 1'b0;
		endcase
		return is_op;
	endfunction

	function automatic void forget_token();
		kw_live      = '1;
		tok_len      = '0;
		tok_start    = '0;
		first_digit  = 1'b0;
		numeric_only = 1'b1;
		has_point    = 1'b0;
	endfunction

	// Classifies the gathered token. A keyword needs both the surviving
	// candidate bit and an exact length, so a prefix of a keyword never matches.
	function automatic token_report_t close_token();
		token_report_t r;
		logic          hit;
		r   = NO_REPORT;
		hit = 1'b0;
		for (int i = 0; i < KW_IN_USE && !hit; i++) begin
			if (kw_live[i] && c_keywords[i].len() == int'(tok_len)) begin
				hit      = 1'b1;
				r.kw_idx = KW_IDX_W'(i);
			end
		end
		if (hit) begin
			r.kind = KIND_KEYWORD;
		end else if (numeric_only && has_point) begin
			r.kind = KIND_REAL;
		end else if (!first_digit) begin
			r.kind = KIND_IDENT;
		end else begin
			r.kind = KIND_BAD_ID;
		end
		r.start  = tok_start;
		r.length = tok_len;
		return r;
	endfunction

	// Takes one character into the lexer state and returns how many results it
	// gives, placed in rep[0] and then rep[1].
	function automatic int lex_char(input logic [7:0] c, input logic eol,
	                                output token_report_t [1:0] rep);
		int                  n;
		logic [OP_IDX_W-1:0] op;
		n = 0;
		rep = '0;
		if (splits_token(c)) begin
			// A pending token is reported before the operator that ends it.
			if (tok_len != 0) begin
				rep[n] = close_token();
				n++;
			end
			if (operator_of(c, op)) begin
				rep[n].kind   = KIND_OPERATOR;
				rep[n].op_idx = op;
				rep[n].start  = line_pos;
				rep[n].length = LEN_W'(1);
				n++;
			end
			forget_token();
		end else begin
			if (tok_len == 0) begin
				tok_start   = line_pos;
				first_digit = is_numeral(c);
			end
			// Keep only the keywords whose letter at this place is c.
			for (int i = 0; i < KW_TABLE; i++) begin
				if (!(tok_len < KW_MAX_LEN && c_keywords[i].len() > int'(tok_len) &&
				      c_keywords[i][tok_len] == c)) begin
					kw_live[i] = 1'b0;
				end
			end
			if (!(is_numeral(c) || c == CH_POINT)) begin
				numeric_only = 1'b0;
			end
			if (c == CH_POINT) begin
				has_point = 1'b1;
			end
			if (tok_len != LEN_MAX) begin
				tok_len++;
			end
			// The last character of a line closes the token it belongs to.
			if (eol) begin
				rep[n] = close_token();
				n++;
				forget_token();
			end
		end
		if (eol) begin
			line_pos = '0;
		end else if (int'(line_pos) < POS_LIMIT) begin
			line_pos++;
		end
		if (n > 0) begin
			rep[n-1].last = 1'b1;
		end
		return n;
	endfunction

	function automatic logic [7:0] any_digit();
		return CH_ZERO + 8'($urandom_range(9));
	endfunction

	function automatic logic [7:0] any_letter();
		int r;
		r = $urandom_range(52);
		if (r < 26) begin
			return "a" + 8'(r);
		end else if (r < 52) begin
			return "A" + 8'(r - 26);
		end
		return "_";
	endfunction

	// Appends one token to the line. Most tokens are well formed (keywords,
	// near-keywords, numbers, names); a few are arbitrary bytes.
	task automatic add_token();
		string w;
		int    pick;
		case ($urandom_range(9))
			0, 1, 2, 3: begin
				w = c_keywords[$urandom_range(KW_TABLE - 1)];
				for (int i = 0; i < w.len(); i++) begin
					line_buf.push_back(w[i]);
				end
				// Sometimes cut a letter off or add one, so the word just misses.
				case ($urandom_range(5))
					0: void'(line_buf.pop_back());
					1: line_buf.push_back(any_letter());
					default: ;
				endcase
			end
			4: begin
				repeat ($urandom_range(3)) line_buf.push_back(any_digit());
				line_buf.push_back(CH_POINT);
				repeat ($urandom_range(3)) line_buf.push_back(any_digit());
				if ($urandom_range(7) == 0) begin
					line_buf.push_back(CH_POINT);
				end
			end
			5: begin
				repeat ($urandom_range(1, 4)) line_buf.push_back(any_digit());
			end
			6, 7: begin
				line_buf.push_back(any_letter());
				repeat ($urandom_range(6)) begin
					pick = $urandom_range(5);
					case (pick)
						0: line_buf.push_back(any_digit());
						1: line_buf.push_back(CH_POINT);
						2: line_buf.push_back("^");
						3: line_buf.push_back("%");
						default: line_buf.push_back(any_letter());
					endcase
				end
			end
			8: begin
				line_buf.push_back(any_digit());
				repeat ($urandom_range(1, 4)) begin
					line_buf.push_back($urandom_range(1) ? any_letter() : CH_POINT);
				end
			end
			default: begin
				repeat ($urandom_range(1, 5)) line_buf.push_back(8'($urandom_range(255)));
			end
		endcase
	endtask

	// Offers one item and holds it until the block takes it; the gaps before it
	// are drawn from gap_pct. Inputs move only at the falling edge.
	task automatic put_char(input logic [7:0] c, input logic eol,
	                        input logic typed, input token_report_t want);
		token_report_t [1:0] rep;
		int                  n;
		while ($urandom_range(99) < gap_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid    <= 1'b1;
		character   <= c;
		end_of_line <= eol;
		do @(posedge clk); while (in_stall !== 1'b0);
		n = lex_char(c, eol, rep);
		if (typed) begin
			expected_reports.push_back(want);
		end else begin
			for (int k = 0; k < n; k++) begin
				expected_reports.push_back(rep[k]);
			end
		end
		chars_sent++;
	endtask

	// Sends the whole line, flagging its last character as the end of the line.
	task automatic send_line();
		for (int i = 0; i < line_buf.size(); i++) begin
			put_char(line_buf[i], i == line_buf.size() - 1, 1'b0, NO_REPORT);
		end
	endtask

	// Stops offering items and waits until every owed result has come out.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
	endtask

	task automatic note_failure(input string why, input token_report_t want);
		failures++;
		if (failures <= 10) begin
			$display("%0t ns: %s: expected kind %0d kw %0d op %0d start %0d len %0d last %0d,",
			         $time, why, want.kind, want.kw_idx, want.op_idx, want.start,
			         want.length, want.last);
			$display("    got kind %0d kw %0d op %0d start %0d len %0d last %0d",
			         kind, keyword_index, operator_index, token_start, token_length,
			         last_of_run);
		end
	endtask

	// The receiver stalls at random, at a rate the current phase sets.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Every result taken is compared, field by field, with the oldest one owed.
	always @(posedge clk) begin
		token_report_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_reports.size() == 0) begin
				note_failure("result with nothing owed", NO_REPORT);
			end else begin
				want = expected_reports.pop_front();
				if (kind !== want.kind || keyword_index !== want.kw_idx ||
				    operator_index !== want.op_idx || token_start !== want.start ||
				    token_length !== want.length || last_of_run !== want.last) begin
					note_failure("wrong result", want);
				end
			end
		end
	end

	// The opening sequence. After reset the position is zero, so the first
	// rows can be written out by hand; the rows in between exercise a token
	// ended by an operator (two results in one step), a real number, a name
	// that starts with a digit, the plain delimiters that give nothing, the
	// zero byte and the top byte as ordinary token characters, and the first
	// and last keywords of the list.
	stim_row_t opening_rows [24] = '{
		'{CH_PLUS,  1'b0, 1'b1, '{KIND_OPERATOR, 5'd0, OP_PLUS, 12'd0, 8'd1, 1'b1}},
		'{"a",      1'b1, 1'b1, '{KIND_IDENT, 5'd0, OP_PLUS, 12'd1, 8'd1, 1'b1}},
		'{"a",      1'b0, 1'b0, NO_REPORT},
		'{"u",      1'b0, 1'b0, NO_REPORT},
		'{"t",      1'b0, 1'b0, NO_REPORT},
		'{"o",      1'b0, 1'b0, NO_REPORT},
		'{CH_MINUS, 1'b0, 1'b0, NO_REPORT},
		'{"1",      1'b0, 1'b0, NO_REPORT},
		'{CH_POINT, 1'b0, 1'b0, NO_REPORT},
		'{"5",      1'b0, 1'b0, NO_REPORT},
		'{CH_STAR,  1'b0, 1'b0, NO_REPORT},
		'{CH_NINE,  1'b0, 1'b0, NO_REPORT},
		'{"^",      1'b0, 1'b0, NO_REPORT},
		'{CH_SLASH, 1'b0, 1'b0, NO_REPORT},
		'{CH_COMMA, 1'b0, 1'b0, NO_REPORT},
		'{CH_SEMI,  1'b1, 1'b0, NO_REPORT},
		'{8'h00,    1'b0, 1'b0, NO_REPORT},
		'{"%",      1'b0, 1'b0, NO_REPORT},
		'{8'hFF,    1'b1, 1'b1, '{KIND_IDENT, 5'd0, OP_PLUS, 12'd0, 8'd3, 1'b1}},
		'{"w",      1'b0, 1'b0, NO_REPORT},
		'{"h",      1'b0, 1'b0, NO_REPORT},
		'{"i",      1'b0, 1'b0, NO_REPORT},
		'{"l",      1'b0, 1'b0, NO_REPORT},
		'{"e",      1'b1, 1'b1, '{KIND_KEYWORD, 5'd31, OP_PLUS, 12'd0, 8'd5, 1'b1}}
	};

	initial begin
		int target;
		int trail;
		forget_token();
		line_pos = '0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (opening_rows[i]) begin
			put_char(opening_rows[i].ch, opening_rows[i].eol, opening_rows[i].typed,
			         opening_rows[i].want);
		end

		// One line holding a token longer than the length counter can count,
		// with ordinary tokens on both sides of it.
		line_buf.delete();
		while (line_buf.size() < 100) begin
			add_token();
			line_buf.push_back(CH_SPACE);
		end
		line_buf.push_back("a");
		repeat (299) line_buf.push_back(any_letter());
		line_buf.push_back(CH_COMMA);
		while (line_buf.size() < 500) begin
			add_token();
			line_buf.push_back(stops[$urandom_range(12)]);
		end
		send_line();

		// Four phases of random lines: no idling, a slow sender, a slow
		// receiver, and both idling now and then. Between phases the sender
		// waits until every owed result has come out.
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 70; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 70; end
				default: begin gap_pct = 15; stall_pct = 15; end
			endcase
			target = chars_sent + 250;
			while (chars_sent < target) begin
				line_buf.delete();
				if ($urandom_range(9) == 0) begin
					// Noise: arbitrary bytes, delimiters included.
					repeat ($urandom_range(1, 20)) line_buf.push_back(8'($urandom_range(255)));
				end else begin
					trail = 1;
					repeat ($urandom_range(1, 8)) begin
						add_token();
						trail = $urandom_range(1, 2);
						repeat (trail) line_buf.push_back(stops[$urandom_range(12)]);
					end
					// Half the lines end inside a token rather than on a delimiter.
					if ($urandom_range(1)) begin
						repeat (trail) void'(line_buf.pop_back());
					end
				end
				send_line();
			end
			drain();
		end

		// Any stray result after the last one owed is caught by the checker.
		repeat (20) @(posedge clk);
		if (failures == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

	initial begin
		#(LIMIT_CYCLES * PERIOD);
		$display("testbench NOT OK");
		$finish;
	end

endmodule
